>>> rtl/core/euq_pkg.sv
// Shared constants, types and arithmetic helpers of the Euler-to-quaternion pipeline.
`default_nettype none

package euq_pkg;

	// Datapath fraction bits and CORDIC iteration count (one pipeline stage per iteration).
	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 16;

	localparam int ANG_FRAC = 30;
	localparam int ANG_W    = 34;
	localparam int DW       = FRAC_BITS + 4;
	localparam int TW       = DW + 18;
	localparam int OUT_FRAC = 14;
	localparam int OUT_ONE  = 16384;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [DW-1:0]    fix_t;
	typedef logic signed [DW:0]      sum_t;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam int     K_SHIFT  = ANG_FRAC - FRAC_BITS;
	localparam longint K_VAL    = (K_SHIFT > 0) ?
		((GAIN_Q30 + (64'sd1 <<< (K_SHIFT - 1))) >>> K_SHIFT) : GAIN_Q30;
	localparam fix_t K_INIT = fix_t'(K_VAL);

	localparam ang_t PI_Q30      = ang_t'(64'sd3373259426);
	localparam ang_t NEG_PI_Q30  = ang_t'(-64'sd3373259426);
	localparam ang_t HALF_PI_Q30 = ang_t'(64'sd1686629713);
	localparam ang_t NEG_HALF_PI = ang_t'(-64'sd1686629713);

	// atan(2^-i) with 30 fraction bits, truncated.
	localparam logic [31:0] ATAN_TAB [24] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// Loose bound on the sine and cosine magnitude after the iterations.
	localparam fix_t TRIG_LIM = fix_t'((64'sd1 <<< FRAC_BITS) + 64'sd16);

	localparam logic signed [2*DW-1:0] PROD_HALF = (2*DW)'(1) <<< (FRAC_BITS - 1);

	localparam int OUT_RSH = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
	localparam int OUT_LSH = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
	localparam logic signed [TW-1:0] OUT_RADD = (OUT_RSH > 0) ?
		(TW'(1) <<< (OUT_RSH - 1)) : '0;
	localparam logic signed [TW-1:0] SAT_HI = TW'(OUT_ONE);
	localparam logic signed [TW-1:0] SAT_LO = -TW'(OUT_ONE);

	// Product of two fractions, rounded half up to the datapath format.
	function automatic fix_t fmul(input fix_t a, input fix_t b);
		logic signed [2*DW-1:0] p;
		p = a * b;
		p = p + PROD_HALF;
		return p[FRAC_BITS+DW-1:FRAC_BITS];
	endfunction

	// Conversion of a component to Q1.14 with saturation at plus or minus one.
	function automatic logic signed [15:0] to_out(input sum_t v);
		logic signed [TW-1:0] t;
		t = TW'(v);
		t = t + OUT_RADD;
		t = t >>> OUT_RSH;
		t = t <<< OUT_LSH;
		if (t > SAT_HI) begin
			t = SAT_HI;
		end else if (t < SAT_LO) begin
			t = SAT_LO;
		end
		return t[15:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/euq_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of half an input angle.
`default_nettype none

module euq_cordic (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_valid,
	input  wire logic signed [15:0]  angle,
	output logic                     out_valid,
	output euq_pkg::fix_t            sin_val,
	output euq_pkg::fix_t            cos_val
);

	localparam int N = euq_pkg::CORDIC_STEPS;

	logic [N+1:0] vld_s;

	euq_pkg::ang_t half_ang;
	euq_pkg::ang_t fold_ang;
	logic          fold_neg;

	euq_pkg::fix_t it_x_s   [0:N];
	euq_pkg::fix_t it_y_s   [0:N];
	euq_pkg::ang_t it_z_s   [0:N];
	logic          it_neg_s [0:N];

	euq_pkg::fix_t nx_x [1:N];
	euq_pkg::fix_t nx_y [1:N];
	euq_pkg::ang_t nx_z [1:N];

	euq_pkg::fix_t sin_s;
	euq_pkg::fix_t cos_s;

	// The angle code with 13 fraction bits, halved, has 30 fraction bits after a 16-bit shift.
	assign half_ang = {{(euq_pkg::ANG_W - 32){angle[15]}}, angle, 16'b0};

	// Half angles beyond a quarter turn are mirrored; the cosine changes sign.
	always_comb begin
		fold_ang = half_ang;
		fold_neg = 1'b0;
		if (half_ang > euq_pkg::HALF_PI_Q30) begin
			fold_ang = euq_pkg::PI_Q30 - half_ang;
			fold_neg = 1'b1;
		end else if (half_ang < euq_pkg::NEG_HALF_PI) begin
			fold_ang = euq_pkg::NEG_PI_Q30 - half_ang;
			fold_neg = 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (!it_z_s[i][euq_pkg::ANG_W-1]) begin
				nx_x[i+1] = it_x_s[i] - (it_y_s[i] >>> i);
				nx_y[i+1] = it_y_s[i] + (it_x_s[i] >>> i);
				nx_z[i+1] = it_z_s[i] - euq_pkg::ang_t'(euq_pkg::ATAN_TAB[i]);
			end else begin
				nx_x[i+1] = it_x_s[i] + (it_y_s[i] >>> i);
				nx_y[i+1] = it_y_s[i] - (it_x_s[i] >>> i);
				nx_z[i+1] = it_z_s[i] + euq_pkg::ang_t'(euq_pkg::ATAN_TAB[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_x_s[0]   <= euq_pkg::K_INIT;
			it_y_s[0]   <= '0;
			it_z_s[0]   <= fold_ang;
			it_neg_s[0] <= fold_neg;
			for (int i = 0; i < N; i++) begin
				it_x_s[i+1]   <= nx_x[i+1];
				it_y_s[i+1]   <= nx_y[i+1];
				it_z_s[i+1]   <= nx_z[i+1];
				it_neg_s[i+1] <= it_neg_s[i];
			end
			sin_s <= it_y_s[N];
			cos_s <= it_neg_s[N] ? -it_x_s[N] : it_x_s[N];
		end
	end

	assign out_valid = vld_s[N+1];
	assign sin_val   = sin_s;
	assign cos_val   = cos_s;

`ifndef SYNTHESIS
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> (it_z_s[0] <= euq_pkg::HALF_PI_Q30 && it_z_s[0] >= euq_pkg::NEG_HALF_PI))
		else $error("folded half angle outside a quarter turn");

	a_sin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N+1] |-> (sin_s <= euq_pkg::TRIG_LIM && sin_s >= -euq_pkg::TRIG_LIM))
		else $error("CORDIC sine beyond unit magnitude");

	a_cos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N+1] |-> (cos_s <= euq_pkg::TRIG_LIM && cos_s >= -euq_pkg::TRIG_LIM))
		else $error("CORDIC cosine beyond unit magnitude");
`endif

endmodule

`default_nettype wire

>>> rtl/core/euler_to_quaternion_unit.sv
// Usage:
// The slave channel takes one item of three Euler angles (roll, pitch, yaw) in
// signed Q2.13 radians; the master channel gives the matching unit quaternion
// in signed Q1.14, each component saturated to plus or minus one.
// An item is taken on any edge where tvalid and tready are both high.
// From acceptance to m_tvalid, one stage folds the half angles, sixteen stages
// hold the CORDIC iterations (one each), one applies the cosine sign, two form
// the pairwise and triple products (one multiplier rank each) and the last adds,
// rounds and saturates into the output register.
// Throughput is one item per cycle while the receiver keeps m_tready high.
// If the output register holds an item that is not taken, the whole pipeline
// freezes and s_tready falls in the same cycle; nothing is lost or repeated,
// and it resumes in the same cycle that m_tready returns.
// Reset clears all valid bits, so no item is presented until one is accepted.
// The block keeps no state between items.
`default_nettype none

module euler_to_quaternion_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata    // quat_x, quat_y, quat_z, quat_w
);

	logic adv;

	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;

	logic          cor_vld_r, cor_vld_p, cor_vld_y;
	euq_pkg::fix_t sr, cr, sp, cp, sy, cy;

	logic          vld_s1, vld_s2, vld_s3;
	euq_pkg::fix_t cc_s1, ss_s1, sc_s1, cs_s1, sy_s1, cy_s1;
	euq_pkg::fix_t w1_s2, w2_s2, x1_s2, x2_s2, y1_s2, y2_s2, z1_s2, z2_s2;
	logic signed [15:0] quat_x_s3, quat_y_s3, quat_z_s3, quat_w_s3;

	euq_pkg::sum_t sum_w, sum_x, sum_y, sum_z;

	// A stall at the output holds every stage at once.
	assign adv      = !vld_s3 || m_tready;
	assign s_tready = adv;

	assign roll_angle  = s_tdata[15:0];
	assign pitch_angle = s_tdata[31:16];
	assign yaw_angle   = s_tdata[47:32];

	euq_cordic u_cor_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.angle     (roll_angle),
		.out_valid (cor_vld_r),
		.sin_val   (sr),
		.cos_val   (cr)
	);

	euq_cordic u_cor_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.angle     (pitch_angle),
		.out_valid (cor_vld_p),
		.sin_val   (sp),
		.cos_val   (cp)
	);

	euq_cordic u_cor_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.angle     (yaw_angle),
		.out_valid (cor_vld_y),
		.sin_val   (sy),
		.cos_val   (cy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cor_vld_r;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		sum_w = euq_pkg::sum_t'(w1_s2) + euq_pkg::sum_t'(w2_s2);
		sum_x = euq_pkg::sum_t'(x1_s2) - euq_pkg::sum_t'(x2_s2);
		sum_y = euq_pkg::sum_t'(y1_s2) + euq_pkg::sum_t'(y2_s2);
		sum_z = euq_pkg::sum_t'(z1_s2) - euq_pkg::sum_t'(z2_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Roll and pitch are combined first; the yaw terms go through with them.
			cc_s1 <= euq_pkg::fmul(cr, cp);
			ss_s1 <= euq_pkg::fmul(sr, sp);
			sc_s1 <= euq_pkg::fmul(sr, cp);
			cs_s1 <= euq_pkg::fmul(cr, sp);
			sy_s1 <= sy;
			cy_s1 <= cy;

			w1_s2 <= euq_pkg::fmul(cc_s1, cy_s1);
			w2_s2 <= euq_pkg::fmul(ss_s1, sy_s1);
			x1_s2 <= euq_pkg::fmul(sc_s1, cy_s1);
			x2_s2 <= euq_pkg::fmul(cs_s1, sy_s1);
			y1_s2 <= euq_pkg::fmul(cs_s1, cy_s1);
			y2_s2 <= euq_pkg::fmul(sc_s1, sy_s1);
			z1_s2 <= euq_pkg::fmul(cc_s1, sy_s1);
			z2_s2 <= euq_pkg::fmul(ss_s1, cy_s1);

			quat_x_s3 <= euq_pkg::to_out(sum_x);
			quat_y_s3 <= euq_pkg::to_out(sum_y);
			quat_z_s3 <= euq_pkg::to_out(sum_z);
			quat_w_s3 <= euq_pkg::to_out(sum_w);
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {quat_w_s3, quat_z_s3, quat_y_s3, quat_x_s3};

`ifndef SYNTHESIS
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (quat_x_s3 <= 16'sd16384 && quat_x_s3 >= -16'sd16384 &&
			quat_y_s3 <= 16'sd16384 && quat_y_s3 >= -16'sd16384 &&
			quat_z_s3 <= 16'sd16384 && quat_z_s3 >= -16'sd16384 &&
			quat_w_s3 <= 16'sd16384 && quat_w_s3 >= -16'sd16384))
		else $error("quaternion component beyond saturation limit");

	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(cor_vld_r == cor_vld_p) && (cor_vld_r == cor_vld_y))
		else $error("angle pipelines out of step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !adv) |=> vld_s2)
		else $error("item dropped from product stage during a stall");
`endif

endmodule

`default_nettype wire
